[hdl/srt_pkg.sv]
// Package for the slot reservation table: sizes, codes and the
// command and status types shared by the controller and the datapath.
// Depends on nothing.
package srt_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int KEEP_W     = 4;
    localparam int OP_W       = 2;
    localparam int WAKE_W     = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX  = 5'd31;
    localparam logic [CNT_W-1:0] FREE_RESET =
        (SLOT_COUNT < 31) ? CNT_W'(SLOT_COUNT) : COUNT_MAX;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd1;

    typedef enum logic [OP_W-1:0] {
        OP_RESERVE = 2'd0,
        OP_CONFIRM = 2'd1,
        OP_CLAIM   = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MARK_FREE     = 2'd0,
        MARK_RESERVED = 2'd1,
        MARK_OCCUPIED = 2'd2
    } mark_t;

    typedef enum logic [WAKE_W-1:0] {
        WAKE_NONE      = 2'd0,
        WAKE_RESERVERS = 2'd1,
        WAKE_CLAIMERS  = 2'd2
    } wake_t;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_WAIT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic load_req;
        logic exec;
    } srt_cmd_t;

    typedef struct packed {
        logic rsp_blocked;
    } srt_stat_t;

endpackage

[hdl/srt_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on srt_pkg for the field widths.
interface srt_req_if;
    logic                       valid;
    logic                       ready;
    logic [srt_pkg::OP_W-1:0]   opcode;
    logic [srt_pkg::IDX_W-1:0]  slot_index;

    modport source (output valid, output opcode, output slot_index, input ready);
    modport sink   (input valid, input opcode, input slot_index, output ready);
endinterface

interface srt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic [srt_pkg::IDX_W-1:0]  granted_slot;
    logic [srt_pkg::CNT_W-1:0]  free_count;
    logic [srt_pkg::CNT_W-1:0]  occupied_count;
    logic [srt_pkg::WAKE_W-1:0] wake_class;

    modport source (output valid, output status, output granted_slot,
                    output free_count, output occupied_count, output wake_class,
                    input ready);
    modport sink   (input valid, input status, input granted_slot,
                    input free_count, input occupied_count, input wake_class,
                    output ready);
endinterface

[hdl/srt_ctrl.sv]
// Controller of the slot reservation table: takes a request word and
// sequences the execute step. Depends on srt_pkg.
module srt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  srt_pkg::srt_stat_t stat,
    output srt_pkg::srt_cmd_t  cmd
);
    import srt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        req_ready    = 1'b0;
        cmd.load_req = 1'b0;
        cmd.exec     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!stat.rsp_blocked)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/srt_datapath.sv]
// Datapath of the slot reservation table: slot marks, counters, the
// lowest-slot search, the update and the response register. Depends on srt_pkg.
module srt_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [srt_pkg::OP_W-1:0]   opcode,
    input  logic [srt_pkg::IDX_W-1:0]  slot_index,
    input  logic                       cfg_we,
    input  logic [srt_pkg::KEEP_W-1:0] cfg_wdata,
    input  srt_pkg::srt_cmd_t          cmd,
    output srt_pkg::srt_stat_t         stat,
    srt_rsp_if.source                  rsp
);
    import srt_pkg::*;

    mark_t              mark_reg [SLOT_COUNT];
    logic [CNT_W-1:0]   free_reg;
    logic [CNT_W-1:0]   occ_reg;
    logic [KEEP_W-1:0]  keep_reg;
    op_t                op_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic               rsp_valid_reg;
    logic               status_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [CNT_W-1:0]   free_out_reg;
    logic [CNT_W-1:0]   occ_out_reg;
    logic [WAKE_W-1:0]  wake_reg;

    logic               free_hit;
    logic [SLOT_W-1:0]  free_pos;
    logic               occ_hit;
    logic [SLOT_W-1:0]  occ_pos;
    logic               idx_ok;
    logic [SLOT_W-1:0]  idx_slot;
    logic               mark_we;
    logic [SLOT_W-1:0]  mark_addr;
    mark_t              mark_val;
    logic [CNT_W-1:0]   free_next;
    logic [CNT_W-1:0]   occ_next;
    logic               status_next;
    logic [IDX_W-1:0]   slot_next;
    wake_t              wake_next;

    always_comb
    begin
        free_hit = 1'b0;
        free_pos = '0;
        occ_hit  = 1'b0;
        occ_pos  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (mark_reg[i] == MARK_FREE)
            begin
                free_hit = 1'b1;
                free_pos = SLOT_W'(i);
            end
            if (mark_reg[i] == MARK_OCCUPIED)
            begin
                occ_hit = 1'b1;
                occ_pos = SLOT_W'(i);
            end
        end
    end

    assign idx_ok   = (int'(idx_reg) < SLOT_COUNT);
    assign idx_slot = SLOT_W'(idx_reg);

    always_comb
    begin
        mark_we     = 1'b0;
        mark_addr   = idx_slot;
        mark_val    = MARK_FREE;
        free_next   = free_reg;
        occ_next    = occ_reg;
        status_next = STATUS_DONE;
        slot_next   = idx_reg;
        wake_next   = WAKE_NONE;
        case (op_reg)
            OP_RESERVE:
            begin
                if ((free_reg > {1'b0, keep_reg}) && free_hit)
                begin
                    mark_we   = 1'b1;
                    mark_addr = free_pos;
                    mark_val  = MARK_RESERVED;
                    free_next = free_reg - 1'b1;
                    slot_next = IDX_W'(free_pos);
                    wake_next = WAKE_RESERVERS;
                end
                else
                begin
                    status_next = STATUS_WAIT;
                end
            end
            OP_CONFIRM:
            begin
                if (idx_ok)
                begin
                    mark_we   = 1'b1;
                    mark_val  = MARK_OCCUPIED;
                    occ_next  = (occ_reg == COUNT_MAX) ? occ_reg : occ_reg + 1'b1;
                    wake_next = WAKE_CLAIMERS;
                end
            end
            OP_CLAIM:
            begin
                if ((occ_reg != '0) && occ_hit)
                begin
                    mark_we   = 1'b1;
                    mark_addr = occ_pos;
                    mark_val  = MARK_RESERVED;
                    occ_next  = occ_reg - 1'b1;
                    slot_next = IDX_W'(occ_pos);
                end
                else
                begin
                    status_next = STATUS_WAIT;
                end
            end
            OP_RELEASE:
            begin
                if (idx_ok)
                begin
                    mark_we   = 1'b1;
                    mark_val  = MARK_FREE;
                    free_next = (free_reg == COUNT_MAX) ? free_reg : free_reg + 1'b1;
                    wake_next = (free_next > {1'b0, keep_reg}) ? WAKE_RESERVERS
                                                               : WAKE_CLAIMERS;
                end
            end
            default:
            begin
                status_next = STATUS_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                mark_reg[i] <= MARK_FREE;
            end
            free_reg      <= FREE_RESET;
            occ_reg       <= '0;
            keep_reg      <= KEEP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                keep_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                if (mark_we)
                begin
                    mark_reg[mark_addr] <= mark_val;
                end
                free_reg      <= free_next;
                occ_reg       <= occ_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg  <= op_t'(opcode);
            idx_reg <= slot_index;
        end
        if (cmd.exec)
        begin
            status_reg   <= status_next;
            slot_reg     <= slot_next;
            free_out_reg <= free_next;
            occ_out_reg  <= occ_next;
            wake_reg     <= wake_next;
        end
    end

    assign stat.rsp_blocked  = rsp_valid_reg && !rsp.ready;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.granted_slot   = slot_reg;
    assign rsp.free_count     = free_out_reg;
    assign rsp.occupied_count = occ_out_reg;
    assign rsp.wake_class     = wake_reg;

`ifndef SYNTHESIS
    a_exec_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !(rsp_valid_reg && !rsp.ready))
        else $error("Execute step overwrote a pending response.");

    a_wait_keeps_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && status_next == STATUS_WAIT)
        |=> ($stable(free_reg) && $stable(occ_reg)))
        else $error("A must-wait operation changed the counters.");

    a_reserve_takes_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && op_reg == OP_RESERVE && status_next == STATUS_DONE)
        |=> (free_reg == $past(free_reg) - 1'b1))
        else $error("A granted reserve did not take exactly one free slot.");

    a_claim_takes_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && op_reg == OP_CLAIM && status_next == STATUS_DONE)
        |=> (occ_reg == $past(occ_reg) - 1'b1))
        else $error("A granted claim did not take exactly one occupied slot.");
`endif

endmodule

[hdl/slot_reservation_table.sv]
// Top level of the slot reservation table: controller plus datapath.
// Depends on srt_pkg, srt_if, srt_ctrl and srt_datapath.
//
//   Channel   Dir  Handshake          Word
//   req       in   valid/ready        opcode, slot_index
//   rsp       out  valid/ready        status, granted_slot, free_count,
//                                     occupied_count, wake_class
//   cfg       in   cfg_we             keep_free in cfg_wdata
//
// The idle state takes each request word, and the execute state then searches
// the slot marks for the lowest matching slot and applies the update.
// The response sits in an output register, so the next request is taken
// while an earlier response waits; the execute step stalls only while
// that register is still full. Reset frees all slots at once and sets
// keep_free to one.
module slot_reservation_table (
    input  logic                       clk,
    input  logic                       rst_n,
    srt_req_if.sink                    req,
    srt_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [srt_pkg::KEEP_W-1:0] cfg_wdata
);
    import srt_pkg::*;

    srt_cmd_t  cmd;
    srt_stat_t stat;
    logic      ctl_ready;

    srt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ctl_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    srt_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (req.opcode),
        .slot_index (req.slot_index),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .rsp        (rsp)
    );

    assign req.ready = ctl_ready;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for slot_reservation_table: directed table, then random phases, most under stalls.
// Answers are checked against a typed step's word, else a predictor in step with the table.
// Depends on srt_pkg, srt_if and the RTL of slot_reservation_table.
module tb_top;
    import srt_pkg::*;

    typedef struct packed {
        logic               status;
        logic [IDX_W-1:0]   slot;
        logic [CNT_W-1:0]   free_cnt;
        logic [CNT_W-1:0]   occ_cnt;
        wake_t              wake;
    } answer_t;

    typedef struct packed {
        logic               is_cfg;
        logic [KEEP_W-1:0]  keep_val;
        op_t                op;
        logic [IDX_W-1:0]   idx;
        logic               typed;
        answer_t            want;
    } step_t;

    localparam answer_t UNTYPED     = '0;
    localparam int      N_STEPS     = 24;
    localparam int      HOLD_CYCLES = 40;
    localparam int      PRINT_CAP   = 100;

    localparam step_t STEPS [N_STEPS] = '{
        '{1'b0, 4'd0, OP_CLAIM, 4'd5, 1'b1, '{STATUS_WAIT, 4'd5, 5'd16, 5'd0, WAKE_NONE}},
        '{1'b0, 4'd0, OP_RESERVE, 4'd9, 1'b1,
            '{STATUS_DONE, 4'd0, 5'd15, 5'd0, WAKE_RESERVERS}},
        '{1'b0, 4'd0, OP_RESERVE, 4'd0, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_CONFIRM, 4'd0, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_CONFIRM, 4'd15, 1'b1,
            '{STATUS_DONE, 4'd15, 5'd14, 5'd2, WAKE_CLAIMERS}},
        '{1'b0, 4'd0, OP_CLAIM, 4'd3, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_CLAIM, 4'd7, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_CLAIM, 4'd0, 1'b1, '{STATUS_WAIT, 4'd0, 5'd14, 5'd0, WAKE_NONE}},
        '{1'b0, 4'd0, OP_RELEASE, 4'd15, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_RELEASE, 4'd15, 1'b1,
            '{STATUS_DONE, 4'd15, 5'd16, 5'd0, WAKE_RESERVERS}},
        '{1'b0, 4'd0, OP_CONFIRM, 4'd1, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_CONFIRM, 4'd1, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_CLAIM, 4'd2, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_CLAIM, 4'd4, 1'b1, '{STATUS_WAIT, 4'd4, 5'd16, 5'd1, WAKE_NONE}},
        '{1'b0, 4'd0, OP_RESERVE, 4'd8, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_RESERVE, 4'd8, 1'b0, UNTYPED},
        '{1'b1, 4'd15, OP_RESERVE, 4'd0, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_RESERVE, 4'd6, 1'b1, '{STATUS_WAIT, 4'd6, 5'd14, 5'd1, WAKE_NONE}},
        '{1'b0, 4'd0, OP_RELEASE, 4'd3, 1'b1,
            '{STATUS_DONE, 4'd3, 5'd15, 5'd1, WAKE_CLAIMERS}},
        '{1'b0, 4'd0, OP_RELEASE, 4'd3, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_RESERVE, 4'd9, 1'b0, UNTYPED},
        '{1'b1, 4'd0, OP_RESERVE, 4'd0, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_RESERVE, 4'd10, 1'b0, UNTYPED},
        '{1'b0, 4'd0, OP_CONFIRM, 4'd4, 1'b0, UNTYPED}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [KEEP_W-1:0]  cfg_wdata;

    srt_req_if req_ch ();
    srt_rsp_if rsp_ch ();

    slot_reservation_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    mark_t              marks [SLOT_COUNT];
    logic [CNT_W-1:0]   free_tot;
    logic [CNT_W-1:0]   occ_tot;
    logic [KEEP_W-1:0]  keep_lim;

    answer_t            answers_due [$];
    answer_t            table_want;
    bit                 table_typed = 1'b0;
    bit                 idle_on = 1'b1;
    bit                 hold_req = 1'b0;

    int                 err_cnt = 0;
    int                 n_words_in = 0;
    int                 n_checked = 0;
    int                 n_waits = 0;
    int                 peak_free = 0;
    int                 peak_occ = 0;

    answer_t            got;
    answer_t            want;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int lowest_slot(mark_t m);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (marks[i] == m)
                return i;
        end
        return -1;
    endfunction

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
        return (v < COUNT_MAX) ? v + 1'b1 : COUNT_MAX;
    endfunction

    function automatic answer_t advance_table(op_t op, logic [IDX_W-1:0] idx);
        answer_t a;
        int      hit;
        a.status = STATUS_DONE;
        a.slot   = idx;
        a.wake   = WAKE_NONE;
        case (op)
            OP_RESERVE:
            begin
                hit = lowest_slot(MARK_FREE);
                if (free_tot > keep_lim && hit >= 0)
                begin
                    marks[hit] = MARK_RESERVED;
                    free_tot   = free_tot - 1'b1;
                    a.slot     = IDX_W'(hit);
                    a.wake     = WAKE_RESERVERS;
                end
                else
                    a.status = STATUS_WAIT;
            end
            OP_CONFIRM:
            begin
                if (int'(idx) < SLOT_COUNT)
                begin
                    marks[idx] = MARK_OCCUPIED;
                    occ_tot    = bump(occ_tot);
                    a.wake     = WAKE_CLAIMERS;
                end
            end
            OP_CLAIM:
            begin
                hit = lowest_slot(MARK_OCCUPIED);
                if (occ_tot != 0 && hit >= 0)
                begin
                    marks[hit] = MARK_RESERVED;
                    occ_tot    = occ_tot - 1'b1;
                    a.slot     = IDX_W'(hit);
                end
                else
                    a.status = STATUS_WAIT;
            end
            default:
            begin
                if (int'(idx) < SLOT_COUNT)
                begin
                    marks[idx] = MARK_FREE;
                    free_tot   = bump(free_tot);
                    a.wake     = (free_tot > keep_lim) ? WAKE_RESERVERS : WAKE_CLAIMERS;
                end
            end
        endcase
        a.free_cnt = free_tot;
        a.occ_cnt  = occ_tot;
        return a;
    endfunction

    task automatic report_mismatch(string what, int got_v, int want_v);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("tb_top: answer %0d %s: got %0d, want %0d", n_checked, what, got_v, want_v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                keep_lim <= cfg_wdata;
            if (req_ch.valid && req_ch.ready)
            begin
                want = advance_table(op_t'(req_ch.opcode), req_ch.slot_index);
                if (table_typed)
                    want = table_want;
                answers_due.push_back(want);
                n_words_in++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status   = rsp_ch.status;
                got.slot     = rsp_ch.granted_slot;
                got.free_cnt = rsp_ch.free_count;
                got.occ_cnt  = rsp_ch.occupied_count;
                got.wake     = wake_t'(rsp_ch.wake_class);
                if (answers_due.size() == 0)
                    report_mismatch("arrived with nothing due", 1, 0);
                else
                begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                    if (got.slot !== want.slot)
                        report_mismatch("granted_slot", int'(got.slot), int'(want.slot));
                    if (got.free_cnt !== want.free_cnt)
                        report_mismatch("free_count", int'(got.free_cnt), int'(want.free_cnt));
                    if (got.occ_cnt !== want.occ_cnt)
                        report_mismatch("occupied_count", int'(got.occ_cnt), int'(want.occ_cnt));
                    if (got.wake !== want.wake)
                        report_mismatch("wake_class", int'(got.wake), int'(want.wake));
                end
                n_checked++;
                if (got.status == STATUS_WAIT)
                    n_waits++;
                if (int'(got.free_cnt) > peak_free)
                    peak_free = int'(got.free_cnt);
                if (int'(got.occ_cnt) > peak_occ)
                    peak_occ = int'(got.occ_cnt);
            end
        end
    end

    // The answer side stalls in short bursts, and once for a long stretch on request.
    initial
    begin : answer_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic offer_word(op_t op, logic [IDX_W-1:0] idx);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.slot_index <= idx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_for_answers();
        req_ch.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_keep_free(logic [KEEP_W-1:0] kf);
        wait_for_answers();
        cfg_we    <= 1'b1;
        cfg_wdata <= kf;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [IDX_W-1:0] pick_slot(mark_t m);
        int cands [$];
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (marks[i] == m)
                cands.push_back(i);
        end
        if (cands.size() == 0 || $urandom_range(0, 3) == 0)
            return IDX_W'($urandom_range(0, SLOT_COUNT - 1));
        return IDX_W'(cands[$urandom_range(0, cands.size() - 1)]);
    endfunction

    // Mostly the normal life of a slot: reserve, confirm it, claim, release it.
    task automatic offer_random_word(int w_res, int w_conf, int w_claim, int w_rel);
        int pick;
        pick = $urandom_range(0, w_res + w_conf + w_claim + w_rel - 1);
        if (pick < w_res)
            offer_word(OP_RESERVE, IDX_W'($urandom_range(0, SLOT_COUNT - 1)));
        else if (pick < w_res + w_conf)
            offer_word(OP_CONFIRM, pick_slot(MARK_RESERVED));
        else if (pick < w_res + w_conf + w_claim)
            offer_word(OP_CLAIM, IDX_W'($urandom_range(0, SLOT_COUNT - 1)));
        else
            offer_word(OP_RELEASE, pick_slot(MARK_RESERVED));
    endtask

    task automatic run_phase(logic [KEEP_W-1:0] kf, int n, int w_res, int w_conf,
                             int w_claim, int w_rel, bit squeeze);
        write_keep_free(kf);
        if (squeeze)
            hold_req = 1'b1;
        repeat (n) offer_random_word(w_res, w_conf, w_claim, w_rel);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = OP_RESERVE;
        req_ch.slot_index = '0;
        rsp_ch.ready      = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
            marks[i] = MARK_FREE;
        free_tot = FREE_RESET;
        occ_tot  = '0;
        keep_lim = KEEP_RESET;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int s = 0; s < N_STEPS; s++)
        begin
            if (STEPS[s].is_cfg)
                write_keep_free(STEPS[s].keep_val);
            else
            begin
                table_typed = STEPS[s].typed;
                table_want  = STEPS[s].want;
                offer_word(STEPS[s].op, STEPS[s].idx);
            end
        end
        table_typed = 1'b0;

        run_phase(4'd1, 260, 3, 3, 2, 2, 1'b0);
        // Release-heavy and confirm-heavy phases push both counts into saturation.
        run_phase(4'd0, 200, 2, 1, 1, 6, 1'b0);
        run_phase(4'd15, 200, 1, 6, 2, 1, 1'b0);
        run_phase(4'd7, 220, 4, 3, 3, 2, 1'b1);
        run_phase(KEEP_W'($urandom_range(2, 13)), 220, 5, 2, 2, 2, 1'b0);
        idle_on = 1'b0;
        run_phase(KEEP_W'($urandom_range(0, 15)), 200, 3, 3, 3, 3, 1'b0);

        wait_for_answers();
        repeat (10) @(negedge clk);
        $display("tb_top: %0d request words, %0d answers checked, %0d of them must-wait",
                 n_words_in, n_checked, n_waits);
        $display("tb_top: keep_free swept 0 to 15; free count peaked at %0d, occupied at %0d",
                 peak_free, peak_occ);
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
